// ===== sv/tsm_pkg.sv =====
// Shared types and constants for the scroll margin control unit.
package tsm_pkg;

    // Page geometry
    localparam int MAX_ROWS  = 256;
    localparam int ROW_CAP   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int ROWS_W    = 9;
    localparam logic [ROWS_W-1:0] PAGE_ROWS_RST = ROWS_W'(24);
    localparam logic [7:0] MARGIN_TOP_RST = 8'd0;
    localparam logic [7:0] MARGIN_BOT_RST = 8'd23;

    // Final bytes handled
    localparam logic [7:0] CH_STBM = 8'h72;
    localparam logic [7:0] CH_IL   = 8'h4C;
    localparam logic [7:0] CH_DL   = 8'h4D;
    localparam logic [7:0] CH_SU   = 8'h53;
    localparam logic [7:0] CH_SD   = 8'h54;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Word widths on the stream ports
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_STBM = 3'd1,
        K_IL   = 3'd2,
        K_DL   = 3'd3,
        K_SU   = 3'd4,
        K_SD   = 3'd5
    } kind_t;

    // Classified command as passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic        act;       // STBM: region valid; SD: scroll issued
        logic [7:0]  top_m1;
        logic [7:0]  bot_m1;
        logic [7:0]  row;
        logic [15:0] count;
        logic        org;
    } cmd_t;

    // One result word
    typedef struct packed {
        logic        clear_pending_wrap;
        logic        cursor_col_home;
        logic [7:0]  new_cursor_row;
        logic        cursor_row_write;
        logic [15:0] scroll_count;
        logic [7:0]  scroll_last_row;
        logic [7:0]  scroll_first_row;
        logic        scroll_down;
        logic        scroll_valid;
        logic        handled;
    } res_t;

endpackage

// ===== sv/tsm_front.sv =====
// Front end: decodes and classifies one input word into a command.
module tsm_front (
    input  logic [tsm_pkg::S_DATA_W-1:0] word_in,
    input  logic [tsm_pkg::ROWS_W-1:0]   page_rows,
    output tsm_pkg::cmd_t                cmd
);

    logic [7:0]  final_char;
    logic        has_intermediates;
    logic        any_subparam;
    logic [4:0]  param_count;
    logic [15:0] first_param;
    logic [15:0] second_param;
    logic [7:0]  cursor_row;
    logic        origin_mode;

    logic [tsm_pkg::ROWS_W-1:0] eff_rows;
    logic [15:0] top_c;
    logic [15:0] bot_c;
    logic [15:0] counted;

    assign final_char        = word_in[7:0];
    assign has_intermediates = word_in[8];
    assign any_subparam      = word_in[9];
    assign param_count       = word_in[14:10];
    assign first_param       = word_in[30:15];
    assign second_param      = word_in[46:31];
    assign cursor_row        = word_in[54:47];
    assign origin_mode       = word_in[55];

    // Page size clamp to 1..cap
    always_comb begin
        eff_rows = page_rows;
        if (page_rows == '0) begin
            eff_rows = tsm_pkg::ROWS_W'(1);
        end else if (page_rows > tsm_pkg::ROWS_W'(tsm_pkg::ROW_CAP)) begin
            eff_rows = tsm_pkg::ROWS_W'(tsm_pkg::ROW_CAP);
        end
    end

    // Margin parameters after defaulting and clamping
    always_comb begin
        top_c = (param_count != 5'd0) ? first_param : 16'd0;
        bot_c = (param_count > 5'd1) ? second_param : 16'd0;
        if (top_c == 16'd0) begin
            top_c = 16'd1;
        end
        if (bot_c == 16'd0 || bot_c > {7'd0, eff_rows}) begin
            bot_c = {7'd0, eff_rows};
        end
    end

    assign counted = (param_count == 5'd0 || first_param == 16'd0) ? 16'd1 : first_param;

    // Classification
    always_comb begin
        cmd        = '0;
        cmd.kind   = tsm_pkg::K_NONE;
        cmd.top_m1 = 8'(top_c - 16'd1);
        cmd.bot_m1 = 8'(bot_c - 16'd1);
        cmd.row    = cursor_row;
        cmd.count  = counted;
        cmd.org    = origin_mode;
        if (!has_intermediates && !(any_subparam && param_count != 5'd0)) begin
            case (final_char)
                tsm_pkg::CH_STBM: begin
                    cmd.kind = tsm_pkg::K_STBM;
                    cmd.act  = (bot_c > top_c);
                end
                tsm_pkg::CH_IL: cmd.kind = tsm_pkg::K_IL;
                tsm_pkg::CH_DL: cmd.kind = tsm_pkg::K_DL;
                tsm_pkg::CH_SU: cmd.kind = tsm_pkg::K_SU;
                tsm_pkg::CH_SD: begin
                    cmd.kind  = tsm_pkg::K_SD;
                    cmd.act   = (param_count == 5'd1) && (first_param != 16'd0);
                    cmd.count = first_param;
                end
                default: cmd.kind = tsm_pkg::K_NONE;
            endcase
        end
    end

endmodule

// ===== sv/tsm_queue.sv =====
// Short command queue between the front and back ends.
module tsm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tsm_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tsm_pkg::cmd_t head_cmd
);

    tsm_pkg::cmd_t entries_reg [tsm_pkg::QDEPTH];
    logic [tsm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tsm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tsm_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full       = (count_reg == tsm_pkg::QCNT_W'(tsm_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == tsm_pkg::QPTR_W'(tsm_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tsm_pkg::QPTR_W'(tsm_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tsm_pkg::QCNT_W'(tsm_pkg::QDEPTH))
        else $error("queue fill count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower fill count");

endmodule

// ===== sv/tsm_back.sv =====
// Back end: holds the margins, carries out commands and registers the result.
module tsm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  tsm_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          res_valid,
    output tsm_pkg::res_t res,
    input  logic          res_ready
);

    logic [7:0]    margin_top_reg, margin_top_next;
    logic [7:0]    margin_bot_reg, margin_bot_next;
    logic          out_valid_reg, out_valid_next;
    tsm_pkg::res_t out_reg, out_next;
    tsm_pkg::res_t r;
    logic          take;

    assign take    = !out_valid_reg || res_ready;
    assign cmd_pop = take && cmd_valid;

    // Execute one command against the current margins
    always_comb begin
        r = '0;
        margin_top_next = margin_top_reg;
        margin_bot_next = margin_bot_reg;
        case (cmd.kind)
            tsm_pkg::K_STBM: begin
                r.handled = 1'b1;
                if (cmd.act) begin
                    margin_top_next    = cmd.top_m1;
                    margin_bot_next    = cmd.bot_m1;
                    r.cursor_row_write = 1'b1;
                    r.new_cursor_row   = cmd.org ? cmd.top_m1 : 8'd0;
                    r.cursor_col_home  = 1'b1;
                    r.clear_pending_wrap = 1'b1;
                end
            end
            tsm_pkg::K_IL, tsm_pkg::K_DL: begin
                r.handled = 1'b1;
                if (cmd.row >= margin_top_reg && cmd.row <= margin_bot_reg) begin
                    r.scroll_valid     = 1'b1;
                    r.scroll_down      = (cmd.kind == tsm_pkg::K_IL);
                    r.scroll_first_row = cmd.row;
                    r.scroll_last_row  = margin_bot_reg;
                    r.scroll_count     = cmd.count;
                    r.cursor_col_home  = 1'b1;
                    r.clear_pending_wrap = 1'b1;
                end
            end
            tsm_pkg::K_SU: begin
                r.handled          = 1'b1;
                r.scroll_valid     = 1'b1;
                r.scroll_first_row = margin_top_reg;
                r.scroll_last_row  = margin_bot_reg;
                r.scroll_count     = cmd.count;
            end
            tsm_pkg::K_SD: begin
                r.handled = 1'b1;
                if (cmd.act) begin
                    r.scroll_valid     = 1'b1;
                    r.scroll_down      = 1'b1;
                    r.scroll_first_row = margin_top_reg;
                    r.scroll_last_row  = margin_bot_reg;
                    r.scroll_count     = cmd.count;
                end
            end
            default: r = '0;
        endcase
    end

    // Output register next state
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take) begin
            out_valid_next = cmd_valid;
            if (cmd_valid) begin
                out_next = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_top_reg <= tsm_pkg::MARGIN_TOP_RST;
            margin_bot_reg <= tsm_pkg::MARGIN_BOT_RST;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop) begin
                margin_top_reg <= margin_top_next;
                margin_bot_reg <= margin_bot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_region_order: assert property (@(posedge aclk) disable iff (!aresetn)
        margin_top_reg < margin_bot_reg)
        else $error("scroll region inverted");

    a_scroll_handled: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.scroll_valid || out_reg.cursor_row_write))
        |-> out_reg.handled)
        else $error("action on an unhandled sequence");

    a_margin_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd.kind == tsm_pkg::K_STBM && cmd.act)
        |=> (margin_top_reg == $past(cmd.top_m1) && margin_bot_reg == $past(cmd.bot_m1)))
        else $error("margins not taken from set-margins");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_ready) |=> $stable(out_reg))
        else $error("stalled result changed");

endmodule

// ===== sv/terminal_scroll_margin_control_unit.sv =====
// Top level of the scroll margin control unit.
// Takes one parsed control sequence per clock on the s_ channel while the queue is
// not full and returns one result word per sequence on the m_ channel, in order. A word
// accepted at one edge is decoded into a two-entry command queue; the back end takes it
// from the queue once its output register is free and registers the result. The sustained
// rate is one word per cycle while m_tready is high; the margin compare is combinational.
// The queue lets the input keep flowing for two words while the output is stalled.
// page_rows is written through the cfg_ port, which is always ready; write it only while
// no words are in flight. Margins reset to rows 0 and 23.
module terminal_scroll_margin_control_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: page_rows
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // Input: final_char[7:0], has_intermediates[8], any_subparam[9], param_count[14:10],
    // first_param[30:15], second_param[46:31], cursor_row[54:47], origin_mode[55]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // Output: handled[0], scroll_valid[1], scroll_down[2], scroll_first_row[10:3],
    // scroll_last_row[18:11], scroll_count[34:19], cursor_row_write[35],
    // new_cursor_row[43:36], cursor_col_home[44], clear_pending_wrap[45], zero[47:46]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    logic [tsm_pkg::ROWS_W-1:0] page_rows_reg;
    tsm_pkg::cmd_t front_cmd;
    tsm_pkg::cmd_t head_cmd;
    tsm_pkg::res_t res;
    logic q_full, q_head_valid, q_pop;

    // Page size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_rows_reg <= tsm_pkg::PAGE_ROWS_RST;
        end else if (cfg_valid) begin
            page_rows_reg <= cfg_data;
        end
    end

    tsm_front u_front (
        .word_in   (s_tdata),
        .page_rows (page_rows_reg),
        .cmd       (front_cmd)
    );

    assign s_tready = !q_full;

    tsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd)
    );

    tsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {2'b00, res};

endmodule
